### rtl/lzwd_pkg.sv
// Shared constants and controller/datapath interface types for the LZW decoder.
// No dependencies.
package lzwd_pkg;

	localparam int MAX_CODE_BITS = 13;
	localparam int STACK_DEPTH   = 64;
	localparam int CODE_W        = MAX_CODE_BITS;
	localparam int FREE_W        = MAX_CODE_BITS + 1;
	localparam int SP_W          = $clog2(STACK_DEPTH);
	localparam int HOLD_W        = MAX_CODE_BITS + 7;
	localparam int CNT_W         = $clog2(HOLD_W + 1);
	localparam int WID_W         = $clog2(MAX_CODE_BITS + 1);

	localparam logic [FREE_W-1:0] DICT_SIZE   = FREE_W'(1) << MAX_CODE_BITS;
	localparam logic [CODE_W-1:0] CODE_CLEAR  = CODE_W'(256);
	localparam logic [CODE_W-1:0] CODE_END    = CODE_W'(257);
	localparam logic [FREE_W-1:0] CODE_FIRST  = FREE_W'(258);
	localparam logic [WID_W-1:0]  START_WIDTH = WID_W'(9);
	localparam logic [WID_W-1:0]  MAX_WIDTH   = WID_W'(MAX_CODE_BITS);
	localparam logic [FREE_W-1:0] START_LIMIT = FREE_W'(512);
	localparam logic [SP_W-1:0]   SP_LAST     = SP_W'(STACK_DEPTH - 1);

	// controller -> datapath
	typedef struct packed {
		logic load_byte;  // shift accepted byte into the bit holder
		logic decode;     // take a code (or set up the error result)
		logic walk;       // one dictionary chain step
		logic emit_put;   // move stack head into the output register
		logic res_put;    // move the pending single result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic err_seen;
		logic have_code;
		logic lit_pend;
		logic is_end;
		logic is_clear;
		logic cur_lit;
		logic stack_full;
		logic idx_zero;
		logic out_free;
	} sts_t;

endpackage

### rtl/lzwd_dpath.sv
// Datapath of the LZW decoder: bit unpacker, dictionary, reverse stack, output register.
// Depends on lzwd_pkg.
module lzwd_dpath import lzwd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic [7:0] in_byte,
	input  logic       out_ready,
	output logic       out_valid,
	output logic       byte_valid,
	output logic [7:0] out_data,
	output logic       last_of_run,
	output logic       end_of_stream,
	output logic       overflow_error
);

	logic [CODE_W-1:0] prefix_mem [DICT_SIZE];
	logic [7:0]        suffix_mem [DICT_SIZE];
	logic [7:0]        stack_mem  [STACK_DEPTH];

	logic [HOLD_W-1:0] holder_q;
	logic [CNT_W-1:0]  held_q;
	logic [WID_W-1:0]  width_q;
	logic [FREE_W-1:0] limit_q;
	logic [FREE_W-1:0] free_q;
	logic [CODE_W-1:0] prev_q;
	logic [7:0]        first_q;
	logic              lit_q;
	logic              err_q;
	logic [CODE_W-1:0] code_q;
	logic [CODE_W-1:0] cur_q;
	logic [SP_W-1:0]   depth_q;
	logic [SP_W-1:0]   idx_q;
	logic              pend_bv_q;
	logic [7:0]        pend_data_q;
	logic              pend_eos_q;

	logic [CODE_W-1:0] pf_rd_q;
	logic [7:0]        sf_rd_q;
	logic [7:0]        stk_rd_q;

	logic              out_valid_q;
	logic              out_bv_q;
	logic [7:0]        out_data_q;
	logic              out_last_q;
	logic              out_eos_q;
	logic              out_err_q;

	logic [HOLD_W-1:0] mask;
	logic [CODE_W-1:0] code;
	logic              kwk;
	logic [CODE_W-1:0] rd_addr;
	logic              stk_we;
	logic [SP_W-1:0]   stk_waddr;
	logic [7:0]        stk_wdata;
	logic              dict_we;
	logic [FREE_W-1:0] free_nx;
	logic              out_free;

	assign mask     = (HOLD_W'(1) << width_q) - HOLD_W'(1);
	assign code     = CODE_W'(holder_q & mask);
	assign kwk      = {1'b0, code} >= free_q;
	assign free_nx  = free_q + FREE_W'(1);
	assign out_free = !out_valid_q || out_ready;
	assign dict_we  = cmd.walk && (cur_q[CODE_W-1:8] == '0) && (depth_q != SP_LAST)
		&& (free_q < DICT_SIZE);

	always_comb begin
		rd_addr   = cur_q;
		stk_we    = 1'b0;
		stk_waddr = depth_q;
		stk_wdata = pf_rd_q[7:0];
		if (cmd.decode && !err_q && !lit_q && (code != CODE_END) && (code != CODE_CLEAR)) begin
			rd_addr   = kwk ? prev_q : code;
			stk_we    = kwk;
			stk_waddr = '0;
			stk_wdata = first_q;
		end else if (cmd.walk && depth_q != SP_LAST) begin
			stk_we = 1'b1;
			if (cur_q[CODE_W-1:8] != '0) begin
				rd_addr   = pf_rd_q;
				stk_wdata = sf_rd_q;
			end else begin
				stk_wdata = cur_q[7:0];
			end
		end
	end

	// dictionary: one write, one registered read
	always_ff @(posedge clk) begin
		if (dict_we) begin
			prefix_mem[free_q[CODE_W-1:0]] <= prev_q;
			suffix_mem[free_q[CODE_W-1:0]] <= cur_q[7:0];
		end
		pf_rd_q <= prefix_mem[rd_addr];
		sf_rd_q <= suffix_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stack_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holder_q <= '0;
			held_q   <= '0;
			width_q  <= START_WIDTH;
			limit_q  <= START_LIMIT;
			free_q   <= CODE_FIRST;
			prev_q   <= '0;
			first_q  <= '0;
			lit_q    <= 1'b0;
			err_q    <= 1'b0;
			code_q   <= '0;
			cur_q    <= '0;
			depth_q  <= '0;
			idx_q    <= '0;
			pend_bv_q   <= 1'b0;
			pend_data_q <= '0;
			pend_eos_q  <= 1'b0;
		end else begin
			if (cmd.load_byte && !err_q) begin
				holder_q <= holder_q | (HOLD_W'(in_byte) << held_q);
				held_q   <= held_q + CNT_W'(8);
			end
			if (cmd.decode) begin
				if (err_q) begin
					pend_bv_q   <= 1'b0;
					pend_data_q <= '0;
					pend_eos_q  <= 1'b0;
				end else if (held_q >= CNT_W'(width_q)) begin
					holder_q <= holder_q >> width_q;
					held_q   <= held_q - CNT_W'(width_q);
					if (lit_q) begin
						lit_q       <= 1'b0;
						prev_q      <= code;
						first_q     <= code[7:0];
						pend_bv_q   <= 1'b1;
						pend_data_q <= code[7:0];
						pend_eos_q  <= 1'b0;
					end else if (code == CODE_END) begin
						holder_q    <= '0;
						held_q      <= '0;
						width_q     <= START_WIDTH;
						limit_q     <= START_LIMIT;
						free_q      <= CODE_FIRST;
						prev_q      <= '0;
						first_q     <= '0;
						pend_bv_q   <= 1'b0;
						pend_data_q <= '0;
						pend_eos_q  <= 1'b1;
					end else if (code == CODE_CLEAR) begin
						width_q <= START_WIDTH;
						limit_q <= START_LIMIT;
						free_q  <= CODE_FIRST;
						lit_q   <= 1'b1;
					end else begin
						code_q  <= code;
						cur_q   <= kwk ? prev_q : code;
						depth_q <= kwk ? SP_W'(1) : '0;
					end
				end
			end
			if (cmd.walk) begin
				if (depth_q == SP_LAST) begin
					// string too long for the stack
					err_q       <= 1'b1;
					pend_bv_q   <= 1'b0;
					pend_data_q <= '0;
					pend_eos_q  <= 1'b0;
				end else if (cur_q[CODE_W-1:8] != '0) begin
					depth_q <= depth_q + SP_W'(1);
					cur_q   <= pf_rd_q;
				end else begin
					first_q <= cur_q[7:0];
					idx_q   <= depth_q;
					prev_q  <= code_q;
					if (dict_we) begin
						free_q <= free_nx;
						if (free_nx >= limit_q && width_q < MAX_WIDTH) begin
							width_q <= width_q + WID_W'(1);
							limit_q <= limit_q << 1;
						end
					end
				end
			end
			if (cmd.emit_put && idx_q != '0) begin
				idx_q <= idx_q - SP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_put || cmd.res_put) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_put) begin
			out_bv_q   <= 1'b1;
			out_data_q <= stk_rd_q;
			out_last_q <= (idx_q == '0);
			out_eos_q  <= 1'b0;
			out_err_q  <= err_q;
		end else if (cmd.res_put) begin
			out_bv_q   <= pend_bv_q;
			out_data_q <= pend_data_q;
			out_last_q <= 1'b1;
			out_eos_q  <= pend_eos_q;
			out_err_q  <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_valid     = out_bv_q;
	assign out_data       = out_data_q;
	assign last_of_run    = out_last_q;
	assign end_of_stream  = out_eos_q;
	assign overflow_error = out_err_q;

	assign sts.err_seen   = err_q;
	assign sts.have_code  = held_q >= CNT_W'(width_q);
	assign sts.lit_pend   = lit_q;
	assign sts.is_end     = code == CODE_END;
	assign sts.is_clear   = code == CODE_CLEAR;
	assign sts.cur_lit    = cur_q[CODE_W-1:8] == '0;
	assign sts.stack_full = depth_q == SP_LAST;
	assign sts.idx_zero   = idx_q == '0;
	assign sts.out_free   = out_free;

endmodule

### rtl/lzwd_ctrl.sv
// Sequencer of the LZW decoder: steps the datapath through decode, walk and emit.
// Depends on lzwd_pkg.
module lzwd_ctrl import lzwd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_EMIT_RD,
		S_EMIT_PUT,
		S_RES
	} state_t;

	state_t state_q;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd           = '0;
		cmd.load_byte = (state_q == S_IDLE) && in_valid;
		cmd.decode    = state_q == S_DECODE;
		cmd.walk      = state_q == S_WALK;
		cmd.emit_put  = (state_q == S_EMIT_PUT) && sts.out_free;
		cmd.res_put   = (state_q == S_RES) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (sts.err_seen) state_q <= S_RES;
					else if (!sts.have_code) state_q <= S_IDLE;
					else if (sts.lit_pend || sts.is_end) state_q <= S_RES;
					else if (sts.is_clear) state_q <= S_IDLE;
					else state_q <= S_WALK;
				end
				S_WALK: begin
					if (sts.stack_full) state_q <= S_RES;
					else if (sts.cur_lit) state_q <= S_EMIT_RD;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_PUT;
				end
				S_EMIT_PUT: begin
					if (sts.out_free) state_q <= sts.idx_zero ? S_IDLE : S_EMIT_RD;
				end
				S_RES: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/lzw_decompressor_13bit.sv
// Top level of the 9..13 bit LZW decoder: sequencer plus datapath.
// Depends on lzwd_pkg, lzwd_ctrl, lzwd_dpath.
//
//  channel  dir  handshake             payload
//  input    in   in_valid / in_ready   in_byte
//  output   out  out_valid / out_ready byte_valid, out_data, last_of_run,
//                                      end_of_stream, overflow_error
//
// A byte that completes no code passes through the decode state only. A byte
// that completes a code is followed by the dictionary walk, one entry per cycle
// through the registered read port, and the stack readout, one read then one
// output load per byte. A clear code returns to idle after decode; literal, end
// and error results pass through the result state.
// Reset is asynchronous; dictionary and stack hold no reset and need no sweep.
// in_ready is high only between items; out_ready low simply holds the
// sequencer at its next output load.
module lzw_decompressor_13bit import lzwd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] out_data,
	output logic       last_of_run,
	output logic       end_of_stream,
	output logic       overflow_error
);

	cmd_t cmd;
	sts_t sts;

	// control: one beat in, zero or more result beats out
	lzwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// unpacker, dictionary, stack and output register
	lzwd_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_byte        (in_byte),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.byte_valid     (byte_valid),
		.out_data       (out_data),
		.last_of_run    (last_of_run),
		.end_of_stream  (end_of_stream),
		.overflow_error (overflow_error)
	);

	// one beat at a time: no new input right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// an error result never carries a byte
	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_error |-> !byte_valid)
		else $error("byte emitted with overflow flag");

	// end code result is a lone, byteless beat
	a_eos_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_stream |-> last_of_run && !byte_valid)
		else $error("malformed end-of-stream beat");

	// byteless beats carry zero data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_data == 8'd0)
		else $error("nonzero data on byteless beat");

endmodule
